[rtl/ftpw_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and bit-plane functions for the font tile planarizer.
package ftpw_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned TILE_IDX_W = 8;
  localparam int unsigned GLYPH_W    = 8;
  localparam int unsigned ACC_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned NUM_BYTES  = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_WIDTH  = 1'd1;

  // pixel formats
  localparam logic FMT_8BPP = 1'b0;
  localparam logic FMT_4BPP = 1'b1;

  // width bases for the two planes
  localparam logic [GLYPH_W-1:0] HIGH_PLANE_BASE = 8'd9;
  localparam logic [GLYPH_W-1:0] LOW_PLANE_BASE  = 8'd17;

  typedef logic [NUM_BYTES-1:0][BYTE_W-1:0] seg_bytes_t;

  typedef struct packed {
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
  } planes_t;

  function automatic planes_t split_planes(input logic fmt, input seg_bytes_t b);
    planes_t p;
    p = '0;
    if (fmt == FMT_8BPP) begin
      for (int i = 0; i < 8; i++) begin
        p.lo[7-i] = b[i][0];
        p.hi[7-i] = b[i][1];
      end
    end else begin
      // two pixels per byte, left pixel in the high nibble
      for (int i = 0; i < 4; i++) begin
        p.lo[7-2*i] = b[i][4];
        p.lo[6-2*i] = b[i][0];
        p.hi[7-2*i] = b[i][5];
        p.hi[6-2*i] = b[i][1];
      end
    end
    return p;
  endfunction

  // lowest set bit, saturating at 7
  function automatic logic [2:0] lowest_pos(input logic [BYTE_W-1:0] v);
    logic [2:0] p;
    p = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (v[i]) p = 3'(i);
    end
    return p;
  endfunction

  function automatic logic [GLYPH_W-1:0] measure_width(input logic [ACC_W-1:0] acc,
                                                       input logic [GLYPH_W-1:0] empty_code);
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [GLYPH_W-1:0] w;
    lo = acc[BYTE_W-1:0];
    hi = acc[ACC_W-1:BYTE_W];
    if (lo == '0) begin
      if (hi == '0) w = empty_code;
      else w = HIGH_PLANE_BASE - GLYPH_W'(lowest_pos(hi));
    end else begin
      w = LOW_PLANE_BASE - GLYPH_W'(lowest_pos(lo));
    end
    return w;
  endfunction

endpackage

[rtl/ftpw_in_if.sv]
`timescale 1ns / 1ps
// Input channel: one 8-byte pixel segment per item.
interface ftpw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [7:0] byte6;
  logic [7:0] byte7;

  modport source (output valid, output byte0, output byte1, output byte2, output byte3,
                  output byte4, output byte5, output byte6, output byte7, input ready);
  modport sink (input valid, input byte0, input byte1, input byte2, input byte3,
                input byte4, input byte5, input byte6, input byte7, output ready);
endinterface

[rtl/ftpw_out_if.sv]
`timescale 1ns / 1ps
// Output channel: plane bytes, tiled offset and glyph width report.
interface ftpw_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  plane_low;
  logic [7:0]  plane_high;
  logic [11:0] byte_offset;
  logic        width_valid;
  logic [7:0]  width_tile;
  logic [7:0]  glyph_width;

  modport source (output valid, output plane_low, output plane_high, output byte_offset,
                  output width_valid, output width_tile, output glyph_width, input ready);
  modport sink (input valid, input plane_low, input plane_high, input byte_offset,
                input width_valid, input width_tile, input glyph_width, output ready);
endinterface

[rtl/ftpw_acc_mem.sv]
`timescale 1ns / 1ps
// Per-column OR accumulator memory: one read and one write port, cleared-on-reset view.
module ftpw_acc_mem #(
  parameter int unsigned DEPTH  = 7,
  parameter int unsigned ADDR_W = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [ftpw_pkg::ACC_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [ftpw_pkg::ACC_W-1:0] wr_data
);

  logic [ftpw_pkg::ACC_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld;
  logic [ftpw_pkg::ACC_W-1:0] rd_raw;
  logic [ftpw_pkg::ACC_W-1:0] fwd_data;
  logic                       rd_vld;
  logic                       fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_raw   <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // same-cycle write to the entry being read wins over the stale read
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      rd_vld  <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      if (rd_en) begin
        rd_vld  <= vld[rd_addr];
        fwd_hit <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  assign rd_data = fwd_hit ? fwd_data : (rd_vld ? rd_raw : '0);

endmodule

[rtl/font_tile_planarizer_width.sv]
`timescale 1ns / 1ps
// Top level: font segment planarizer with per-tile glyph width measurement.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+--------------------------------------------------
//  pix     | in  | valid/ready      | byte0..byte7 pixel segment
//  res     | out | valid/ready      | plane_low, plane_high, byte_offset, width report
//  cfg     | in  | cfg_we, no wait  | cfg_index, cfg_data
//
// One item per cycle sustained unless the output stalls. Stage 0 splits planes, computes
// the offset and reads the column accumulator; stage 1 merges, writes back and measures
// the width into the output register. The accumulator memory has one read and one write
// port, so a back-to-back hit on one column is forwarded. Reset (rst, synchronous) clears
// position, configuration, valid flags and accumulator valid bits at once. A stalled
// output holds stage 1; an empty stage 1 still takes a new item while the result waits.
module font_tile_planarizer_width #(
  parameter int unsigned TILE_COLUMNS = 7,
  parameter int unsigned TILE_HEIGHT  = 12,
  parameter int unsigned TILE_ROWS    = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ftpw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ftpw_pkg::CFG_DATA_W-1:0]   cfg_data,
  ftpw_in_if.sink                           pix,
  ftpw_out_if.source                        res
);

  localparam int unsigned CW = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
  localparam int unsigned RW = (TILE_HEIGHT > 1) ? $clog2(TILE_HEIGHT) : 1;
  localparam int unsigned TW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam logic [CW-1:0] COL_LAST  = CW'(TILE_COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(TILE_HEIGHT - 1);
  localparam logic [TW-1:0] TROW_LAST = TW'(TILE_ROWS - 1);

  // configuration
  logic                          pixel_format;
  logic [ftpw_pkg::GLYPH_W-1:0]  empty_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= ftpw_pkg::FMT_8BPP;
      empty_code   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ftpw_pkg::REG_PIXEL_FORMAT: pixel_format <= cfg_data[0];
        ftpw_pkg::REG_EMPTY_WIDTH:  empty_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid;
  logic s1_adv;
  logic out_valid;
  logic accept;

  assign s1_adv    = s1_valid && (!out_valid || res.ready);
  assign pix.ready = !s1_valid || s1_adv;
  assign accept    = pix.valid && pix.ready;

  // raster position
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [TW-1:0] trow;

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      trow <= '0;
    end else if (accept) begin
      if (col == COL_LAST) begin
        col <= '0;
        if (row == ROW_LAST) begin
          row  <= '0;
          trow <= (trow == TROW_LAST) ? '0 : trow + 1'b1;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // stage 0: plane split and tiled offset
  ftpw_pkg::seg_bytes_t seg;
  ftpw_pkg::planes_t    planes;
  logic [31:0]          tile_full;
  logic [31:0]          off_full;

  assign seg[0] = pix.byte0;
  assign seg[1] = pix.byte1;
  assign seg[2] = pix.byte2;
  assign seg[3] = pix.byte3;
  assign seg[4] = pix.byte4;
  assign seg[5] = pix.byte5;
  assign seg[6] = pix.byte6;
  assign seg[7] = pix.byte7;

  always_comb begin
    planes    = ftpw_pkg::split_planes(pixel_format, seg);
    tile_full = 32'(trow) * 32'(TILE_COLUMNS) + 32'(col);
    off_full  = (tile_full * 32'(TILE_HEIGHT) + 32'(row)) << 1;
  end

  // stage 1 registers
  ftpw_pkg::planes_t                s1_planes;
  logic [ftpw_pkg::OFFSET_W-1:0]   s1_off;
  logic [ftpw_pkg::TILE_IDX_W-1:0] s1_tile;
  logic                            s1_last;
  logic [CW-1:0]                   s1_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_planes <= planes;
      s1_off    <= off_full[ftpw_pkg::OFFSET_W-1:0];
      s1_tile   <= tile_full[ftpw_pkg::TILE_IDX_W-1:0];
      s1_last   <= (row == ROW_LAST);
      s1_col    <= col;
    end
  end

  // accumulator read-modify-write
  logic [ftpw_pkg::ACC_W-1:0] acc_rd;
  logic [ftpw_pkg::ACC_W-1:0] acc;
  logic [ftpw_pkg::ACC_W-1:0] acc_wr;

  assign acc    = acc_rd | s1_planes;
  assign acc_wr = s1_last ? '0 : acc;

  ftpw_acc_mem #(
    .DEPTH  (TILE_COLUMNS),
    .ADDR_W (CW)
  ) u_acc_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (acc_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (acc_wr)
  );

  // output register
  logic [7:0]                      o_lo;
  logic [7:0]                      o_hi;
  logic [ftpw_pkg::OFFSET_W-1:0]   o_off;
  logic                            o_wvalid;
  logic [ftpw_pkg::TILE_IDX_W-1:0] o_tile;
  logic [ftpw_pkg::GLYPH_W-1:0]    o_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_lo     <= s1_planes.lo;
      o_hi     <= s1_planes.hi;
      o_off    <= s1_off;
      o_wvalid <= s1_last;
      o_tile   <= s1_last ? s1_tile : '0;
      o_width  <= s1_last ? ftpw_pkg::measure_width(acc, empty_code) : '0;
    end
  end

  assign res.valid       = out_valid;
  assign res.plane_low   = o_lo;
  assign res.plane_high  = o_hi;
  assign res.byte_offset = o_off;
  assign res.width_valid = o_wvalid;
  assign res.width_tile  = o_tile;
  assign res.glyph_width = o_width;

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (32'(col) < TILE_COLUMNS) && (32'(row) < TILE_HEIGHT) && (32'(trow) < TILE_ROWS))
    else $error("raster position out of range");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item lost before stage 1");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("stage 1 item lost before output");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_wvalid) |->
      ((o_width >= 8'd2 && o_width <= 8'd17) || o_width == empty_code))
    else $error("glyph width out of range");

endmodule

[dv/ftpw_checker.sv]
`timescale 1ns / 1ps
// Checker: predicts plane bytes, tiled offsets and glyph widths and compares each result.
module ftpw_checker #(
  parameter int unsigned TILE_COLUMNS = 7,
  parameter int unsigned TILE_HEIGHT  = 12,
  parameter int unsigned TILE_ROWS    = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ftpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftpw_pkg::CFG_DATA_W-1:0] cfg_data,
  ftpw_in_if                              pix,
  ftpw_out_if                             res,
  output int                              errors,
  output int                              pending
);

  typedef struct packed {
    logic [7:0]  plane_low;
    logic [7:0]  plane_high;
    logic [11:0] byte_offset;
    logic        width_valid;
    logic [7:0]  width_tile;
    logic [7:0]  glyph_width;
  } tile_result_t;

  tile_result_t planar_q[$];

  logic        fmt;
  logic [7:0]  empty_code;
  logic [15:0] col_or [TILE_COLUMNS];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned tile_row_pos;

  // position of the rightmost set pixel bit, 7 when none below bit 7
  function automatic logic [2:0] first_set_bit(input logic [7:0] v);
    logic [2:0] p;
    bit found;
    p = 3'd7;
    found = 1'b0;
    for (int k = 0; k < 7; k++) begin
      if (!found && v[k]) begin
        p = 3'(k);
        found = 1'b1;
      end
    end
    return p;
  endfunction

  function automatic logic [7:0] glyph_span(input logic [15:0] acc, input logic [7:0] code);
    if (acc[7:0] != 8'd0) return 8'd17 - 8'(first_set_bit(acc[7:0]));
    if (acc[15:8] != 8'd0) return 8'd9 - 8'(first_set_bit(acc[15:8]));
    return code;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic predict_segment(input ftpw_pkg::seg_bytes_t b);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] acc;
    int unsigned tile;
    int unsigned src;
    int unsigned nib;
    tile_result_t r;
    lo = '0;
    hi = '0;
    for (int px = 0; px < 8; px++) begin
      // 4bpp: two pixels per byte, left one in the high nibble
      src = (fmt == ftpw_pkg::FMT_4BPP) ? px / 2 : px;
      nib = (fmt == ftpw_pkg::FMT_4BPP && (px % 2) == 0) ? 4 : 0;
      lo[7-px] = b[src][nib];
      hi[7-px] = b[src][nib+1];
    end
    tile = tile_row_pos * TILE_COLUMNS + col_pos;
    r = '0;
    r.plane_low   = lo;
    r.plane_high  = hi;
    r.byte_offset = 12'(2 * (tile * TILE_HEIGHT + row_pos));
    acc = col_or[col_pos] | {hi, lo};
    if (row_pos + 1 >= TILE_HEIGHT) begin
      r.width_valid = 1'b1;
      r.width_tile  = 8'(tile);
      r.glyph_width = glyph_span(acc, empty_code);
      col_or[col_pos] = '0;
    end else begin
      col_or[col_pos] = acc;
    end
    planar_q.push_back(r);
    col_pos++;
    if (col_pos >= TILE_COLUMNS) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= TILE_HEIGHT) begin
        row_pos = 0;
        tile_row_pos++;
        if (tile_row_pos >= TILE_ROWS) tile_row_pos = 0;
      end
    end
  endtask

  task automatic check_result(input tile_result_t got);
    tile_result_t want;
    if (planar_q.size() == 0) begin
      report_mismatch("result with no segment pending, offset", got.byte_offset, -1);
      return;
    end
    want = planar_q.pop_front();
    if (got.plane_low !== want.plane_low)
      report_mismatch("plane_low", got.plane_low, want.plane_low);
    if (got.plane_high !== want.plane_high)
      report_mismatch("plane_high", got.plane_high, want.plane_high);
    if (got.byte_offset !== want.byte_offset)
      report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
    if (got.width_valid !== want.width_valid)
      report_mismatch("width_valid", got.width_valid, want.width_valid);
    if (got.width_tile !== want.width_tile)
      report_mismatch("width_tile", got.width_tile, want.width_tile);
    if (got.glyph_width !== want.glyph_width)
      report_mismatch("glyph_width", got.glyph_width, want.glyph_width);
  endtask

  always @(posedge clk) begin
    tile_result_t got;
    if (rst) begin
      fmt          = ftpw_pkg::FMT_8BPP;
      empty_code   = '0;
      col_pos      = 0;
      row_pos      = 0;
      tile_row_pos = 0;
      for (int c = 0; c < TILE_COLUMNS; c++) col_or[c] = '0;
      planar_q.delete();
    end else begin
      if (pix.valid && pix.ready)
        predict_segment({pix.byte7, pix.byte6, pix.byte5, pix.byte4,
                         pix.byte3, pix.byte2, pix.byte1, pix.byte0});
      if (res.valid && res.ready) begin
        got.plane_low   = res.plane_low;
        got.plane_high  = res.plane_high;
        got.byte_offset = res.byte_offset;
        got.width_valid = res.width_valid;
        got.width_tile  = res.width_tile;
        got.glyph_width = res.glyph_width;
        check_result(got);
      end
      if (cfg_we) begin
        case (cfg_index)
          ftpw_pkg::REG_PIXEL_FORMAT: fmt = cfg_data[0];
          ftpw_pkg::REG_EMPTY_WIDTH:  empty_code = cfg_data;
          default: ;
        endcase
      end
    end
    pending = planar_q.size();
  end

endmodule

[dv/font_tile_planarizer_width_tb.sv]
`timescale 1ns / 1ps
// Testbench top: stimulus, idle/stall pattern, configuration phases and the verdict.
module font_tile_planarizer_width_tb;

  localparam int unsigned TILE_COLUMNS = 7;
  localparam int unsigned TILE_HEIGHT  = 12;
  localparam int unsigned TILE_ROWS    = 20;
  localparam int unsigned CHUNKS       = 12;   // 12 x 100 random items plus the directed ones
  localparam int unsigned CHUNK_ITEMS  = 100;

  // how one tile column is drawn over the rows of a tile
  typedef enum int {
    STY_BLANK,      // no plane bits: empty width code
    STY_HIGH_EDGE,  // plane 1 only, nothing right of the edge pixel: width 2..9
    STY_LOW_EDGE,   // plane 0 up to the edge pixel, plane 1 anywhere: width 10..17
    STY_NOISE       // unconstrained bytes
  } row_style_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [ftpw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ftpw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ftpw_in_if  pix ();
  ftpw_out_if res ();

  int          src_idle;   // percent of cycles the sender holds valid low
  int          sink_idle;  // percent of cycles the receiver holds ready low
  int          errors;
  int          pending;
  int unsigned seg_count;  // items accepted since reset, tracks raster position
  logic        cur_fmt;
  row_style_t  col_style [TILE_COLUMNS];
  int          col_edge  [TILE_COLUMNS];

  always #4 clk = ~clk;

  font_tile_planarizer_width #(
    .TILE_COLUMNS(TILE_COLUMNS),
    .TILE_HEIGHT (TILE_HEIGHT),
    .TILE_ROWS   (TILE_ROWS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix      (pix),
    .res      (res)
  );

  ftpw_checker #(
    .TILE_COLUMNS(TILE_COLUMNS),
    .TILE_HEIGHT (TILE_HEIGHT),
    .TILE_ROWS   (TILE_ROWS)
  ) tile_check (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix      (pix),
    .res      (res),
    .errors   (errors),
    .pending  (pending)
  );

  // receiver backpressure, redrawn every falling edge
  initial res.ready = 1'b0;
  always @(negedge clk) res.ready = ($urandom_range(0, 99) >= sink_idle);

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic ftpw_pkg::seg_bytes_t seg_fill(input logic [7:0] v);
    ftpw_pkg::seg_bytes_t b;
    for (int k = 0; k < ftpw_pkg::NUM_BYTES; k++) b[k] = v;
    return b;
  endfunction

  function automatic ftpw_pkg::seg_bytes_t seg_at(input int idx, input logic [7:0] v);
    ftpw_pkg::seg_bytes_t b;
    b = '0;
    b[idx] = v;
    return b;
  endfunction

  // random segment shaped by the column's style; the edge styles keep plane 0 clear right of the edge
  function automatic ftpw_pkg::seg_bytes_t glyph_row(input logic fmt, input row_style_t sty,
                                                     input int edge_px);
    ftpw_pkg::seg_bytes_t b;
    int bi;
    int b0;
    b = {$urandom, $urandom};
    for (int k = 0; k < 8; k++) begin
      bi = (fmt == ftpw_pkg::FMT_4BPP) ? k / 2 : k;
      b0 = (fmt == ftpw_pkg::FMT_4BPP && (k % 2) == 0) ? 4 : 0;
      case (sty)
        STY_BLANK: begin
          b[bi][b0]   = 1'b0;
          b[bi][b0+1] = 1'b0;
        end
        STY_HIGH_EDGE: begin
          b[bi][b0] = 1'b0;
          if (k > edge_px) b[bi][b0+1] = 1'b0;
        end
        STY_LOW_EDGE: begin
          if (k > edge_px) b[bi][b0] = 1'b0;
        end
        default: ;
      endcase
    end
    return b;
  endfunction

  // entered and left at a falling edge; valid stays high across back-to-back items
  task automatic drive_segment(input ftpw_pkg::seg_bytes_t b);
    while ($urandom_range(0, 99) < src_idle) begin
      pix.valid = 1'b0;
      @(negedge clk);
    end
    pix.valid = 1'b1;
    pix.byte0 = b[0];
    pix.byte1 = b[1];
    pix.byte2 = b[2];
    pix.byte3 = b[3];
    pix.byte4 = b[4];
    pix.byte5 = b[5];
    pix.byte6 = b[6];
    pix.byte7 = b[7];
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    seg_count++;
    @(negedge clk);
  endtask

  // sender holds off until every result is back, plus pipeline slack
  task automatic wait_idle();
    pix.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // both registers back to back, only while the block is idle
  task automatic set_config(input logic fmt, input logic [7:0] code);
    cfg_we    = 1'b1;
    cfg_index = ftpw_pkg::REG_PIXEL_FORMAT;
    cfg_data  = ftpw_pkg::CFG_DATA_W'(fmt);
    @(negedge clk);
    cfg_index = ftpw_pkg::REG_EMPTY_WIDTH;
    cfg_data  = code;
    @(negedge clk);
    cfg_we  = 1'b0;
    cur_fmt = fmt;
  endtask

  initial begin
    int unsigned col;
    int unsigned row;
    pix.valid = 1'b0;
    pix.byte0 = '0;
    pix.byte1 = '0;
    pix.byte2 = '0;
    pix.byte3 = '0;
    pix.byte4 = '0;
    pix.byte5 = '0;
    pix.byte6 = '0;
    pix.byte7 = '0;
    seg_count = 0;
    cur_fmt   = ftpw_pkg::FMT_8BPP;
    src_idle  = 0;
    sink_idle = 0;
    for (int c = 0; c < TILE_COLUMNS; c++) begin
      col_style[c] = STY_NOISE;
      col_edge[c]  = 7;
    end

    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed, 8bpp: field extremes and each plane bit alone
    src_idle  = 30;
    sink_idle = 58;
    set_config(ftpw_pkg::FMT_8BPP, 8'h5A);
    drive_segment(seg_fill(8'h00));
    drive_segment(seg_fill(8'hFF));
    drive_segment(seg_fill(8'h01));
    drive_segment(seg_fill(8'h02));
    drive_segment(seg_fill(8'h10));
    drive_segment(seg_fill(8'h20));
    drive_segment(seg_fill(8'h03));
    drive_segment(seg_at(0, 8'h03));
    drive_segment(seg_at(7, 8'h03));
    drive_segment(64'h55AA_55AA_55AA_55AA);

    // directed, 4bpp mid-bitmap: nibble bits, edge bytes, ignored upper half
    wait_idle();
    set_config(ftpw_pkg::FMT_4BPP, 8'hFF);
    drive_segment(seg_fill(8'h00));
    drive_segment(seg_fill(8'hFF));
    drive_segment(seg_fill(8'h11));
    drive_segment(seg_fill(8'h22));
    drive_segment(seg_fill(8'h01));
    drive_segment(seg_fill(8'h02));
    drive_segment(seg_fill(8'h10));
    drive_segment(seg_fill(8'h20));
    drive_segment(seg_at(0, 8'h33));
    drive_segment(seg_at(3, 8'h33));
    drive_segment(64'hFFFF_FFFF_0000_0000);

    // random chunks: drain, reconfigure, then a run of shaped glyph rows
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      wait_idle();
      case (chunk / 4)
        0: begin
          src_idle  = 30;
          sink_idle = 58;
        end
        1: begin
          src_idle  = 58;
          sink_idle = 30;
        end
        default: begin
          src_idle  = 0;
          sink_idle = 0;
        end
      endcase
      // first chunks pin the register extremes, the rest are random
      case (chunk)
        0:       set_config(ftpw_pkg::FMT_8BPP, 8'h00);
        1:       set_config(ftpw_pkg::FMT_4BPP, 8'hFF);
        2:       set_config(ftpw_pkg::FMT_4BPP, 8'h00);
        3:       set_config(ftpw_pkg::FMT_8BPP, 8'hFF);
        default: set_config(1'($urandom_range(0, 1)), 8'($urandom));
      endcase
      repeat (CHUNK_ITEMS) begin
        col = seg_count % TILE_COLUMNS;
        row = (seg_count / TILE_COLUMNS) % TILE_HEIGHT;
        // new tile in this column: pick how it is drawn
        if (row == 0) begin
          col_style[col] = row_style_t'($urandom_range(0, 3));
          col_edge[col]  = $urandom_range(0, 7);
        end
        drive_segment(glyph_row(cur_fmt, col_style[col], col_edge[col]));
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ftpw_pkg.sv
rtl/ftpw_in_if.sv
rtl/ftpw_out_if.sv
rtl/ftpw_acc_mem.sv
rtl/font_tile_planarizer_width.sv
dv/ftpw_checker.sv
dv/font_tile_planarizer_width_tb.sv
